FILE: hw/rtl/fppa_pkg.sv
// Shared types, codes and constants of the fuzzy position PID axis.
package fppa_pkg;

  // Request codes of an input item
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PROP  = 2'd0;
  localparam logic [1:0] CFG_INTEG = 2'd1;
  localparam logic [1:0] CFG_DERIV = 2'd2;
  localparam logic [1:0] CFG_LIMIT = 2'd3;

  // Register reset values
  localparam logic [31:0] PROP_RST  = 32'd3355443;
  localparam logic [31:0] INTEG_RST = 32'd168;
  localparam logic [31:0] DERIV_RST = 32'd5368709;
  localparam logic [14:0] LIMIT_RST = 15'd20;

  // Defaults of the top level parameters
  localparam int RULE_GRID_DEF     = 7;
  localparam int TARGET_MARGIN_DEF = 8;

  // Fixed field widths and fraction bits
  localparam int TGT_W   = 24;
  localparam int POS_W   = 32;
  localparam int RULE_W  = 16;
  localparam int LIM_W   = 15;
  localparam int QB      = 16;
  localparam int GB      = 24;
  localparam int NTABLES = 3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIVST,
    ST_DIV,
    ST_LOC,
    ST_WP,
    ST_RULE,
    ST_PID,
    ST_FIN,
    ST_DONE
  } fppa_state_e;

endpackage

FILE: hw/rtl/fppa_ram.sv
// Generic simple dual port RAM with registered read.
module fppa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 147
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/fppa_div.sv
// Two lane restoring divider, one quotient bit per lane per cycle, shared divisor.
module fppa_div #(
  parameter int DVD_W = 50,
  parameter int DVS_W = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dvd_a_i,
  input  logic [DVD_W-1:0] dvd_b_i,
  input  logic [DVS_W-1:0] dvs_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quo_a_o,
  output logic [DVD_W-1:0] quo_b_o
);

  localparam int CW = $clog2(DVD_W);

  logic             run_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   rem_a_q, rem_b_q;
  logic [DVD_W-1:0] quo_a_q, quo_b_q;
  logic [DVS_W:0]   sh_a, sh_b;
  logic             ge_a, ge_b;

  // shift next dividend bit into each partial remainder
  always_comb begin
    sh_a = {rem_a_q[DVS_W-1:0], quo_a_q[DVD_W-1]};
    sh_b = {rem_b_q[DVS_W-1:0], quo_b_q[DVD_W-1]};
    ge_a = sh_a >= {1'b0, dvs_q};
    ge_b = sh_b >= {1'b0, dvs_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DVD_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q   <= dvs_i;
      rem_a_q <= '0;
      rem_b_q <= '0;
      quo_a_q <= dvd_a_i;
      quo_b_q <= dvd_b_i;
    end else if (run_q) begin
      rem_a_q <= ge_a ? sh_a - {1'b0, dvs_q} : sh_a;
      rem_b_q <= ge_b ? sh_b - {1'b0, dvs_q} : sh_b;
      quo_a_q <= {quo_a_q[DVD_W-2:0], ge_a};
      quo_b_q <= {quo_b_q[DVD_W-2:0], ge_b};
    end
  end

  assign done_o  = done_q;
  assign quo_a_o = quo_a_q;
  assign quo_b_o = quo_b_q;

endmodule

FILE: hw/rtl/fuzzy_position_pid_axis.sv
// Top level of the fuzzy self-tuning positional PID axis controller.
// A control tick passes the error, divider start, divide, locate, weight, rule, PID and finish
// states before its result register is loaded: the normalizing division runs one quotient bit
// per cycle over a 48 + HB bit dividend (HB being the bit count of the half grid width), then
// twelve rule reads stream through the rule RAM port and six partial products form the PID sum
// on one shared multiplier. When either normalized value falls off the rule grid or the divisor
// is zero, the weight and rule steps are skipped. Rule loads and clears go straight to the done
// state and load their result once the output register is free; a stalled receiver holds an
// item there. One item is in work at a time; a finished result waits in the output register
// while the next item is taken. Rules live in a RAM that has no reset: every entry reached by
// a tick must be loaded first. Rule writes and rule reads belong to different items, so they
// never overlap.
module fuzzy_position_pid_axis #(
  parameter int RULE_GRID     = fppa_pkg::RULE_GRID_DEF,
  parameter int TARGET_MARGIN = fppa_pkg::TARGET_MARGIN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic signed [23:0] target_pos_i,
  input  logic signed [15:0] encoder_delta_i,
  input  logic [1:0]  rule_table_sel_i,
  input  logic [2:0]  rule_row_i,
  input  logic [2:0]  rule_col_i,
  input  logic signed [15:0] rule_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] speed_cmd_o,
  output logic signed [31:0] position_o,
  output logic        target_reached_o
);

  localparam int H      = (RULE_GRID - 1) / 2;
  localparam int HB     = $clog2(H + 1);
  localparam int QB     = fppa_pkg::QB;
  localparam int QONE   = 1 << QB;
  localparam int DVD_W  = 48 + HB;
  localparam int DVS_W  = fppa_pkg::TGT_W + 1;
  localparam int VW     = HB + QB + 1;
  localparam int UW     = VW + 1;
  localparam int KW     = $clog2(2 * H + 1);
  localparam int DEPTH  = fppa_pkg::NTABLES * RULE_GRID * RULE_GRID;
  localparam int AW     = $clog2(DEPTH);
  localparam int GB     = fppa_pkg::GB;

  fppa_pkg::fppa_state_e state_q, state_d;

  // configuration registers
  logic [31:0] prop_q, integ_q, deriv_q;
  logic [14:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q  <= fppa_pkg::PROP_RST;
      integ_q <= fppa_pkg::INTEG_RST;
      deriv_q <= fppa_pkg::DERIV_RST;
      lim_q   <= fppa_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fppa_pkg::CFG_PROP:  prop_q  <= cfg_data_i;
        fppa_pkg::CFG_INTEG: integ_q <= cfg_data_i;
        fppa_pkg::CFG_DERIV: deriv_q <= cfg_data_i;
        fppa_pkg::CFG_LIMIT: lim_q   <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // state and working registers
  logic signed [31:0] pos_q, prev_q, esum_q, e_q, sum_q;
  logic signed [32:0] ec_q;
  logic signed [23:0] t_q;
  logic [DVS_W-1:0]   dvs_q;
  logic               dneg_q, dzero_q, reached_q, ok_q, pphi_q;
  logic [3:0]         cnt_q;
  logic [KW-1:0]      ke_q, kc_q;
  logic [16:0]        el_q, eh_q, cl_q, ch_q;
  logic [32:0]        wprod_q [4];
  logic signed [49:0] rprod_q;
  logic signed [48:0] oacc_q [fppa_pkg::NTABLES];
  logic signed [51:0] pprod_q;
  logic signed [71:0] pacc_q;
  logic signed [15:0] res_speed_q;
  logic signed [31:0] res_pos_q;
  logic               res_reached_q;
  logic               out_valid_q;
  logic signed [15:0] speed_q;
  logic signed [31:0] position_q;
  logic               reached_out_q;

  logic accept, out_load;
  assign accept   = in_valid_i && in_ready_o;
  assign out_load = (state_q == fppa_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  // rule RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [15:0]       ram_rdata;
  logic              load_ok;

  assign load_ok = (rule_table_sel_i <= 2'd2) && (int'(rule_row_i) < RULE_GRID) &&
                   (int'(rule_col_i) < RULE_GRID);
  assign ram_waddr = AW'((int'(rule_table_sel_i) * RULE_GRID + int'(rule_row_i)) * RULE_GRID +
                         int'(rule_col_i));

  fppa_ram #(.WIDTH(fppa_pkg::RULE_W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rule_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // error terms of a tick
  logic signed [32:0] diff, s33, ec_d;
  logic signed [31:0] e_d, sum_d;
  logic signed [25:0] t26, div26, dmag26;
  logic [32:0]        apos, atgt;

  always_comb begin
    diff  = {pos_q[31], pos_q} - 33'(t_q);
    e_d   = (diff[32] != diff[31]) ? (diff[32] ? 32'sh80000000 : 32'sh7fffffff) : diff[31:0];
    ec_d  = {e_d[31], e_d} - {prev_q[31], prev_q};
    s33   = {esum_q[31], esum_q} + {e_d[31], e_d};
    sum_d = (s33[32] != s33[31]) ? (s33[32] ? 32'sh80000000 : 32'sh7fffffff) : s33[31:0];
    t26   = 26'(t_q);
    div26 = t_q[23] ? t26 - 26'(TARGET_MARGIN) : t26 + 26'(TARGET_MARGIN);
    dmag26 = div26[25] ? -div26 : div26;
    apos  = pos_q[31] ? -{pos_q[31], pos_q} : {pos_q[31], pos_q};
    atgt  = t_q[23] ? -33'(t_q) : 33'(t_q);
  end

  // divider operands: |x| * H * 2^16
  logic [32:0]      e_abs;
  logic [33:0]      ec_abs;
  logic [DVD_W-1:0] dvd_a, dvd_b, quo_a, quo_b;
  logic             div_start, div_done;

  always_comb begin
    e_abs  = e_q[31] ? -{e_q[31], e_q} : {e_q[31], e_q};
    ec_abs = ec_q[32] ? -{ec_q[32], ec_q} : {ec_q[32], ec_q};
    dvd_a  = (DVD_W'(e_abs[31:0]) * DVD_W'(H)) << QB;
    dvd_b  = (DVD_W'(ec_abs[31:0]) * DVD_W'(H)) << QB;
  end

  fppa_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_a_i (dvd_a),
    .dvd_b_i (dvd_b),
    .dvs_i   (dvs_q),
    .done_o  (div_done),
    .quo_a_o (quo_a),
    .quo_b_o (quo_b)
  );

  // cell and upper weight of a normalized value, with its range flag
  function automatic logic [KW+17:0] locate(input logic [DVD_W-1:0] qmag, input logic neg);
    logic [UW-1:0] u;
    logic [KW-1:0] k;
    logic [16:0]   whi;
    logic          ok;
    ok = qmag <= DVD_W'(H * QONE);
    u  = neg ? UW'(H * QONE) - UW'(qmag[VW-1:0]) : UW'(H * QONE) + UW'(qmag[VW-1:0]);
    if (u >= UW'((2 * H - 1) * QONE)) begin
      k   = KW'(2 * H - 1);
      whi = 17'(u - UW'((2 * H - 1) * QONE));
    end else begin
      k   = KW'(u >> QB);
      whi = {1'b0, u[QB-1:0]};
    end
    return {ok, k, whi};
  endfunction

  logic [KW+17:0] loc_a, loc_b;
  assign loc_a = locate(quo_a, e_q[31] ^ dneg_q);
  assign loc_b = locate(quo_b, ec_q[32] ^ dneg_q);

  // rule read pipeline indexes
  logic [3:0] jm1, jm2;
  logic [1:0] rtab;
  logic [1:0] rcor;
  assign jm1  = cnt_q - 4'd1;
  assign jm2  = cnt_q - 4'd2;
  assign rtab = cnt_q[3:2];
  assign rcor = cnt_q[1:0];

  // PID operands
  logic signed [33:0] g_p, g_i, g_d, g_sel, x_sel;
  logic signed [17:0] mop;
  logic [1:0]         term;

  always_comb begin
    g_p  = $signed({2'b00, prop_q})  + 34'($signed(oacc_q[0][48:16]));
    g_i  = $signed({2'b00, integ_q}) + 34'($signed(oacc_q[1][48:16]));
    g_d  = $signed({2'b00, deriv_q}) + 34'($signed(oacc_q[2][48:16]));
    term = cnt_q[2:1];
    case (term)
      2'd0:    begin g_sel = g_p; x_sel = 34'(e_q);   end
      2'd1:    begin g_sel = g_d; x_sel = 34'(ec_q);  end
      default: begin g_sel = g_i; x_sel = 34'(sum_q); end
    endcase
    mop = cnt_q[0] ? 18'($signed(x_sel[33:17])) : {1'b0, x_sel[16:0]};
  end

  // command: truncate toward zero, clamp, zero once target passed
  logic signed [47:0] cq, lim48;
  always_comb begin
    cq    = pacc_q[71:24] + 48'((pacc_q[71] && (pacc_q[GB-1:0] != '0)) ? 1 : 0);
    lim48 = 48'(lim_q);
    if (cq > lim48) begin
      cq = lim48;
    end else if (cq < -lim48) begin
      cq = -lim48;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fppa_pkg::ST_IDLE:  if (accept) begin
        state_d = (req_type_i == fppa_pkg::REQ_TICK) ? fppa_pkg::ST_ERR : fppa_pkg::ST_DONE;
      end
      fppa_pkg::ST_ERR:   state_d = fppa_pkg::ST_DIVST;
      fppa_pkg::ST_DIVST: state_d = fppa_pkg::ST_DIV;
      fppa_pkg::ST_DIV:   if (div_done) state_d = fppa_pkg::ST_LOC;
      fppa_pkg::ST_LOC: begin
        state_d = (loc_a[KW+17] && loc_b[KW+17] && !dzero_q) ? fppa_pkg::ST_WP
                                                              : fppa_pkg::ST_PID;
      end
      fppa_pkg::ST_WP:    if (cnt_q == 4'd3) state_d = fppa_pkg::ST_RULE;
      fppa_pkg::ST_RULE:  if (cnt_q == 4'd13) state_d = fppa_pkg::ST_PID;
      fppa_pkg::ST_PID:   if (cnt_q == 4'd6) state_d = fppa_pkg::ST_FIN;
      fppa_pkg::ST_FIN:   state_d = fppa_pkg::ST_DONE;
      fppa_pkg::ST_DONE:  if (out_load) state_d = fppa_pkg::ST_IDLE;
      default:            state_d = fppa_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = '0;
    unique case (state_q)
      fppa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_we     = in_valid_i && (req_type_i == fppa_pkg::REQ_LOAD) && load_ok;
      end
      fppa_pkg::ST_DIVST: div_start = 1'b1;
      fppa_pkg::ST_RULE: begin
        ram_raddr = AW'((int'(rtab) * RULE_GRID + int'(kc_q) + int'(rcor[0])) * RULE_GRID +
                        int'(ke_q) + int'(rcor[1]));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fppa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control state: axis state, step counter, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      prev_q      <= '0;
      esum_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        fppa_pkg::ST_IDLE: begin
          if (accept && req_type_i == fppa_pkg::REQ_TICK) begin
            pos_q <= pos_q + 32'(encoder_delta_i);
          end else if (accept && req_type_i == fppa_pkg::REQ_CLEAR) begin
            pos_q  <= '0;
            prev_q <= '0;
            esum_q <= '0;
          end
        end
        fppa_pkg::ST_ERR: begin
          prev_q <= e_d;
          esum_q <= sum_d;
        end
        fppa_pkg::ST_LOC: cnt_q <= '0;
        fppa_pkg::ST_WP:  cnt_q <= (cnt_q == 4'd3) ? 4'd0 : cnt_q + 4'd1;
        fppa_pkg::ST_RULE: cnt_q <= (cnt_q == 4'd13) ? 4'd0 : cnt_q + 4'd1;
        fppa_pkg::ST_PID: cnt_q <= cnt_q + 4'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      fppa_pkg::ST_IDLE: begin
        t_q           <= target_pos_i;
        res_speed_q   <= '0;
        res_reached_q <= 1'b0;
        res_pos_q     <= (req_type_i == fppa_pkg::REQ_CLEAR) ? 32'sd0 : pos_q;
      end
      fppa_pkg::ST_ERR: begin
        e_q       <= e_d;
        ec_q      <= ec_d;
        sum_q     <= sum_d;
        dvs_q     <= dmag26[DVS_W-1:0];
        dneg_q    <= div26[25];
        dzero_q   <= (div26 == 26'sd0);
        reached_q <= apos > atgt;
        res_pos_q <= pos_q;
      end
      fppa_pkg::ST_LOC: begin
        ok_q  <= loc_a[KW+17] && loc_b[KW+17] && !dzero_q;
        ke_q  <= loc_a[KW+16:17];
        kc_q  <= loc_b[KW+16:17];
        eh_q  <= loc_a[16:0];
        ch_q  <= loc_b[16:0];
        el_q  <= 17'(QONE) - loc_a[16:0];
        cl_q  <= 17'(QONE) - loc_b[16:0];
        oacc_q[0] <= '0;
        oacc_q[1] <= '0;
        oacc_q[2] <= '0;
        pacc_q    <= '0;
      end
      fppa_pkg::ST_WP: begin
        wprod_q[cnt_q[1:0]] <= 33'((cnt_q[1] ? eh_q : el_q) * (cnt_q[0] ? ch_q : cl_q));
      end
      fppa_pkg::ST_RULE: begin
        if (ok_q && cnt_q >= 4'd1 && cnt_q <= 4'd12) begin
          rprod_q <= $signed({1'b0, wprod_q[jm1[1:0]]}) * $signed(ram_rdata);
        end
        if (ok_q && cnt_q >= 4'd2 && jm2[3:2] != 2'd3) begin
          oacc_q[jm2[3:2]] <= oacc_q[jm2[3:2]] + 49'(rprod_q);
        end
      end
      fppa_pkg::ST_PID: begin
        if (cnt_q <= 4'd5) begin
          pprod_q <= g_sel * mop;
          pphi_q  <= cnt_q[0];
        end
        if (cnt_q >= 4'd1) begin
          pacc_q <= pacc_q + (pphi_q ? (72'(pprod_q) <<< 17) : 72'(pprod_q));
        end
      end
      fppa_pkg::ST_FIN: begin
        res_speed_q   <= reached_q ? 16'sd0 : cq[15:0];
        res_reached_q <= reached_q;
      end
      default: ;
    endcase
    if (out_load) begin
      speed_q       <= res_speed_q;
      position_q    <= res_pos_q;
      reached_out_q <= res_reached_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign speed_cmd_o      = speed_q;
  assign position_o       = position_q;
  assign target_reached_o = reached_out_q;

endmodule

FILE: hw/rtl/fppa_checker.sv
// Port level checker of the fuzzy position PID axis, bound to the top level.
module fppa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic signed [15:0] speed_cmd_o,
  input logic signed [31:0] position_o,
  input logic        target_reached_o
);

  // a pending result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // a pending result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(speed_cmd_o) && $stable(position_o))
    else $error("pending result changed");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new item taken while one is in work");

  // command is zero once the target is passed
  a_reached_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_reached_o |-> speed_cmd_o == 16'sd0)
    else $error("nonzero command past target");

  // clamp is symmetric, so the most negative code never shows
  a_no_minneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> speed_cmd_o != 16'sh8000)
    else $error("command outside symmetric range");

endmodule

bind fuzzy_position_pid_axis fppa_checker u_fppa_checker (.*);

FILE: verif/fppa_result_checker.sv
`timescale 1ns / 100ps
// Result checker of the fuzzy position PID axis: predicts each result and compares it.
module fppa_result_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         req_type_i,
  input  logic signed [23:0] target_pos_i,
  input  logic signed [15:0] encoder_delta_i,
  input  logic [1:0]         rule_table_sel_i,
  input  logic [2:0]         rule_row_i,
  input  logic [2:0]         rule_col_i,
  input  logic signed [15:0] rule_value_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] speed_cmd_i,
  input  logic signed [31:0] position_i,
  input  logic               target_reached_i,
  output int                 errors_o,
  output int                 outstanding_o
);

  localparam int     GRID   = fppa_pkg::RULE_GRID_DEF;
  localparam int     HALF   = (GRID - 1) / 2;
  localparam int     MARGIN = fppa_pkg::TARGET_MARGIN_DEF;
  localparam longint QONE   = 64'sd65536;
  localparam longint GONE   = 64'sd16777216;

  typedef struct {
    logic signed [15:0] speed_cmd;
    logic signed [31:0] position;
    logic               reached;
  } axis_result_t;

  axis_result_t        pending_results[$];
  logic [31:0]         prop_gain, integ_gain, deriv_gain;
  logic [14:0]         limit;
  logic signed [31:0]  pos_accum, prev_err, err_sum;
  logic signed [15:0]  rules[fppa_pkg::NTABLES][GRID][GRID];
  int                  errors;

  assign errors_o = errors;
  assign outstanding_o = pending_results.size();

  function automatic longint floor_div(longint v, longint d);
    longint q;
    q = v / d;
    if ((v % d) != 0 && v < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // cell index and the two weights of a normalized value; 0 when off the grid
  function automatic bit grid_cell(longint v, output int k, output longint wlo,
                                   output longint whi);
    longint h;
    h = HALF * QONE;
    k = 0;
    wlo = 0;
    whi = 0;
    if (v > h || v < -h) return 0;
    if (v >= (HALF - 1) * QONE) k = 2 * HALF - 1;
    else k = int'((v + h) / QONE);
    wlo = longint'(k - HALF + 1) * QONE - v;
    whi = v - longint'(k - HALF) * QONE;
    return 1;
  endfunction

  function automatic longint gain_offset(int sel, int ke, longint el, longint eh,
                                         int kc, longint cl, longint ch);
    longint s;
    s = el * cl * longint'(rules[sel][kc][ke])
      + el * ch * longint'(rules[sel][kc+1][ke])
      + eh * cl * longint'(rules[sel][kc][ke+1])
      + eh * ch * longint'(rules[sel][kc+1][ke+1]);
    return floor_div(s, QONE);
  endfunction

  // one control tick: updates the loop state and returns the speed command
  function automatic axis_result_t control_tick(longint tgt, logic signed [15:0] dlt);
    axis_result_t r;
    longint pos, e, ec, sum, dv, en, ecn, el, eh, cl, ch, a, b, bq, bf, cmd, lim;
    longint g[3], x[3], off[3], gh, gl;
    int ke, kc;
    pos_accum = pos_accum + 32'(dlt);
    pos = longint'(pos_accum);
    e = sat32(pos - tgt);
    ec = e - longint'(prev_err);
    sum = sat32(longint'(err_sum) + e);
    err_sum = 32'(sum);
    prev_err = 32'(e);
    dv = (tgt >= 0) ? tgt + MARGIN : tgt - MARGIN;
    off = '{0, 0, 0};
    if (dv != 0) begin
      en = e * HALF * QONE / dv;
      ecn = ec * HALF * QONE / dv;
      if (grid_cell(en, ke, el, eh) && grid_cell(ecn, kc, cl, ch)) begin
        for (int i = 0; i < 3; i++) off[i] = gain_offset(i, ke, el, eh, kc, cl, ch);
      end
    end
    // table order is Kp, Ki, Kd
    g[0] = longint'(prop_gain) + off[0];   x[0] = e;
    g[1] = longint'(deriv_gain) + off[2];  x[1] = ec;
    g[2] = longint'(integ_gain) + off[1];  x[2] = sum;
    a = 0;
    b = 0;
    for (int i = 0; i < 3; i++) begin
      gh = floor_div(g[i], GONE);
      gl = g[i] - gh * GONE;
      a += gh * x[i];
      b += gl * x[i];
    end
    bq = floor_div(b, GONE);
    bf = b - bq * GONE;
    cmd = a + bq;
    if (cmd < 0 && bf != 0) cmd += 1;
    lim = longint'(limit);
    if (cmd > lim) cmd = lim;
    if (cmd < -lim) cmd = -lim;
    r.reached = ((pos < 0) ? -pos : pos) > ((tgt < 0) ? -tgt : tgt);
    if (r.reached) cmd = 0;
    r.speed_cmd = 16'(cmd);
    r.position = pos_accum;
    return r;
  endfunction

  // prediction on accepted input items, comparison on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    axis_result_t r, want;
    if (!rst_ni) begin
      prop_gain = fppa_pkg::PROP_RST;
      integ_gain = fppa_pkg::INTEG_RST;
      deriv_gain = fppa_pkg::DERIV_RST;
      limit = fppa_pkg::LIMIT_RST;
      pos_accum = '0;
      prev_err = '0;
      err_sum = '0;
      pending_results.delete();
      errors = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fppa_pkg::CFG_PROP:  prop_gain = cfg_data_i;
          fppa_pkg::CFG_INTEG: integ_gain = cfg_data_i;
          fppa_pkg::CFG_DERIV: deriv_gain = cfg_data_i;
          fppa_pkg::CFG_LIMIT: limit = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected: cmd %0d pos %0d reached %0b",
                   $time, speed_cmd_i, position_i, target_reached_i);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (speed_cmd_i !== want.speed_cmd) begin
            $display("%0t: speed_cmd expected %0d actual %0d", $time, want.speed_cmd,
                     speed_cmd_i);
            errors++;
          end
          if (position_i !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position,
                     position_i);
            errors++;
          end
          if (target_reached_i !== want.reached) begin
            $display("%0t: target_reached expected %0b actual %0b", $time, want.reached,
                     target_reached_i);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        r.speed_cmd = '0;
        r.reached = 1'b0;
        if (req_type_i == fppa_pkg::REQ_TICK) begin
          r = control_tick(longint'(target_pos_i), encoder_delta_i);
        end else if (req_type_i == fppa_pkg::REQ_CLEAR) begin
          pos_accum = '0;
          prev_err = '0;
          err_sum = '0;
          r.position = '0;
        end else begin
          if (req_type_i == fppa_pkg::REQ_LOAD && rule_table_sel_i < fppa_pkg::NTABLES &&
              rule_row_i < GRID && rule_col_i < GRID)
            rules[rule_table_sel_i][rule_row_i][rule_col_i] = rule_value_i;
          r.position = pos_accum;
        end
        pending_results.push_back(r);
      end
    end
  end

endmodule

FILE: verif/fuzzy_position_pid_axis_tb.sv
`timescale 1ns / 100ps
// Testbench top of the fuzzy position PID axis: stimulus, stalls and verdict.
module fuzzy_position_pid_axis_tb;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int         IDLE_WAIT = 120;
  localparam int         STALL_LIMIT = 5000;

  logic               clk_i, rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i, in_ready_o;
  logic [1:0]         req_type_i;
  logic signed [23:0] target_pos_i;
  logic signed [15:0] encoder_delta_i;
  logic [1:0]         rule_table_sel_i;
  logic [2:0]         rule_row_i, rule_col_i;
  logic signed [15:0] rule_value_i;
  logic               out_valid_o, out_ready_i;
  logic signed [15:0] speed_cmd_o;
  logic signed [31:0] position_o;
  logic               target_reached_o;
  int                 errors, outstanding;
  int                 burst_left, idle_cycles, ready_mode, mode_cycles;
  longint             axis_pos;

  fuzzy_position_pid_axis i_dut (.*);

  fppa_result_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .target_pos_i, .encoder_delta_i,
    .rule_table_sel_i, .rule_row_i, .rule_col_i, .rule_value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .speed_cmd_i(speed_cmd_o),
    .position_i(position_o), .target_reached_i(target_reached_o),
    .errors_o(errors), .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls: the ready mode is redrawn at random whenever the mode counter wraps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_mode <= 0;
      mode_cycles <= 0;
    end else begin
      mode_cycles <= (mode_cycles == 149) ? 0 : mode_cycles + 1;
      if (mode_cycles == 149) ready_mode <= int'($urandom_range(0, 3));
      case (ready_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) == 0);
        2: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] req, logic signed [23:0] tgt,
                           logic signed [15:0] dlt, logic [1:0] sel, logic [2:0] row,
                           logic [2:0] col, logic signed [15:0] val);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    target_pos_i <= tgt;
    encoder_delta_i <= dlt;
    rule_table_sel_i <= sel;
    rule_row_i <= row;
    rule_col_i <= col;
    rule_value_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // track position for well-formed move sequences
    if (req == fppa_pkg::REQ_CLEAR) axis_pos = 0;
    else if (req == fppa_pkg::REQ_TICK) axis_pos = axis_pos + dlt;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(40, 120))
                                              : int'($urandom_range(1, 10));
    end
  endtask

  task automatic send_tick(longint tgt, longint dlt);
    send_item(fppa_pkg::REQ_TICK, 24'(tgt), 16'(dlt), 2'($urandom), 3'($urandom),
              3'($urandom), 16'($urandom));
  endtask

  task automatic send_clear();
    send_item(fppa_pkg::REQ_CLEAR, 24'($urandom), 16'($urandom), 2'($urandom), 3'($urandom),
              3'($urandom), 16'($urandom));
  endtask

  // register writes only with the block drained
  task automatic write_regs(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                            logic [14:0] lim);
    logic [31:0] vals[4];
    vals = '{kp, ki, kd, 32'(lim)};
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (outstanding != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 2'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly approach moves from a cleared axis, plus loads and noise
  task automatic random_phase(int count);
    longint tgt, step, n;
    int pick;
    while (count > 0) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 8) begin
        send_item(2'($urandom), 24'($urandom), 16'($urandom), 2'($urandom), 3'($urandom),
                  3'($urandom), 16'($urandom));
        count--;
      end else if (pick < 16) begin
        send_item(fppa_pkg::REQ_LOAD, 24'($urandom), 16'($urandom), 2'($urandom_range(0, 2)),
                  3'($urandom_range(0, 6)), 3'($urandom_range(0, 6)), 16'($urandom));
        count--;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          send_clear();
          count--;
        end
        if ($urandom_range(0, 9) < 7) tgt = longint'($urandom_range(0, 4000)) - 2000;
        else tgt = longint'($signed(24'($urandom)));
        n = longint'($urandom_range(4, 30));
        for (int i = 0; i < n; i++) begin
          step = (tgt - axis_pos) / longint'($urandom_range(1, 6)) +
                 longint'($urandom_range(0, 20)) - 10;
          if (step > 32767) step = 32767;
          if (step < -32768) step = -32768;
          send_tick(tgt, step);
          count--;
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    req_type_i = fppa_pkg::REQ_CLEAR;
    target_pos_i = '0;
    encoder_delta_i = '0;
    rule_table_sel_i = '0;
    rule_row_i = '0;
    rule_col_i = '0;
    rule_value_i = '0;
    axis_pos = 0;
    burst_left = 5;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every rule entry is written before any tick
    for (int s = 0; s < fppa_pkg::NTABLES; s++)
      for (int r = 0; r < fppa_pkg::RULE_GRID_DEF; r++)
        for (int c = 0; c < fppa_pkg::RULE_GRID_DEF; c++)
          send_item(fppa_pkg::REQ_LOAD, 24'($urandom), 16'($urandom), 2'(s), 3'(r), 3'(c),
                    16'(longint'($urandom_range(0, 2048)) - 1024));

    // directed: ignored loads, spare code, rule extremes, field extremes
    send_item(fppa_pkg::REQ_LOAD, '1, '1, 2'd3, 3'd2, 3'd2, 16'sh7fff);
    send_item(fppa_pkg::REQ_LOAD, '0, '0, 2'd1, 3'd7, 3'd0, 16'sh7fff);
    send_item(fppa_pkg::REQ_LOAD, '0, '0, 2'd1, 3'd0, 3'd7, 16'sh8000);
    send_item(REQ_SPARE, '1, '1, 2'd0, 3'd0, 3'd0, 16'sh1234);
    send_item(fppa_pkg::REQ_LOAD, '0, '0, 2'd0, 3'd3, 3'd3, 16'sh7fff);
    send_item(fppa_pkg::REQ_LOAD, '0, '0, 2'd2, 3'd3, 3'd3, 16'sh8000);
    send_item(fppa_pkg::REQ_LOAD, '0, '0, 2'd1, 3'd6, 3'd6, 16'sh8000);
    send_tick(0, 0);
    send_tick(0, 1);
    send_tick(-1, -32768);
    send_tick(8388607, 32767);
    send_tick(-8388608, -32768);
    send_tick(-8, 16);
    send_clear();
    send_tick(100, 90);
    send_tick(100, 8);
    send_tick(100, 2);
    send_tick(100, 5);
    send_tick(-100, -200);
    send_clear();
    send_tick(-8388608, 32767);
    for (int i = 0; i < 4; i++) send_tick(8388607, -32768);

    random_phase(350);
    write_regs('1, '1, '1, 15'h7fff);
    random_phase(350);
    write_regs('0, '0, '0, '0);
    random_phase(150);
    write_regs($urandom_range(0, 32'h0800_0000), $urandom_range(0, 32'h0010_0000),
               $urandom_range(0, 32'h0800_0000), 15'($urandom_range(1, 2000)));
    random_phase(350);
    write_regs(fppa_pkg::PROP_RST, fppa_pkg::INTEG_RST, fppa_pkg::DERIV_RST,
               fppa_pkg::LIMIT_RST);
    random_phase(150);

    if (in_valid_i) in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
